[rtl/abmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abmt_pkg
// Shared types and constants for the alpha-beta multi-target tracker.
// ----------------------------------------------------------------------------
package abmt_pkg;

  localparam int MaxTracksDefault = 8;
  localparam logic [15:0] GateReset = 16'd500;
  localparam logic [7:0]  MissLimitReset = 8'd10;

  // configuration register indexes
  localparam logic CfgGate  = 1'b0;
  localparam logic CfgLimit = 1'b1;

  // one stored track
  typedef struct packed {
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [16:0] vx;
    logic signed [16:0] vy;
    logic [7:0]         miss;
  } track_t;

  // floor half of a 19 bit sum, saturated to 16 bit signed
  function automatic logic signed [15:0] half_sat16(input logic signed [18:0] s);
    logic signed [18:0] h;
    begin
      h = s >>> 1;
      if (h > 19'sd32767) half_sat16 = 16'sh7fff;
      else if (h < -19'sd32768) half_sat16 = 16'sh8000;
      else half_sat16 = h[15:0];
    end
  endfunction

  // floor half saturated to 17 bit signed
  function automatic logic signed [16:0] half_sat17(input logic signed [18:0] s);
    logic signed [18:0] h;
    begin
      h = s >>> 1;
      if (h > 19'sd65535) half_sat17 = 17'sh0ffff;
      else if (h < -19'sd65536) half_sat17 = 17'sh10000;
      else half_sat17 = h[16:0];
    end
  endfunction

endpackage

[rtl/abmt_dist_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abmt_dist_unit
// Shared squared-distance unit: one squaring per cycle, x and y terms accumulated.
// ----------------------------------------------------------------------------
module abmt_dist_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [15:0] ax,
  input  logic signed [15:0] ay,
  input  logic signed [15:0] bx,
  input  logic signed [15:0] by,
  output logic               done,
  output logic [33:0]        sum_sq
);
  import abmt_pkg::*;

  logic               phase;
  logic               busy;
  logic signed [16:0] diff;
  logic [33:0]        sq;
  logic [33:0]        acc;

  // select the axis for this cycle and square it
  assign diff = phase ? ({ay[15], ay} - {by[15], by}) : ({ax[15], ax} - {bx[15], bx});
  assign sq = 34'($signed(diff) * $signed(diff));

  // x term loaded on start, then the y term added while busy; done follows busy
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      if (start) begin
        phase <= 1'b1;
        busy  <= 1'b1;
        acc   <= sq;
      end else if (busy) begin
        busy  <= 1'b0;
        phase <= 1'b0;
        acc   <= acc + sq;
      end else begin
        phase <= 1'b0;
      end
      done <= busy;
    end
  end

  assign sum_sq = acc;

endmodule

[rtl/alpha_beta_multi_target_tracker_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_beta_multi_target_tracker_unit
// Nearest-neighbor alpha-beta tracker over an ordered table of tracks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one scan of zero to two points;
//   a count of three is ignored. Output channel (out_valid/out_ready) returns
//   one word per live track in table order, last set on the final word; an
//   empty table gives one word with any_track clear.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the gate
//   radius (index 0) and miss limit (index 1); always ready.
// Sequencing:
//   A scan runs through a sequencer around one shared squared-distance unit
//   (start, wait and compare states per track per point), a decision, then
//   miss, update, append, compaction and emit steps, the passes at one entry
//   per cycle, the emit pass holding its word while out_ready is low. in_ready
//   stays low from an accepted scan until its last output word is taken.
// Reset clears the table count and loads register defaults; stored tracks
// are not cleared. A stalled receiver simply holds the current output word.
// ----------------------------------------------------------------------------
module alpha_beta_multi_target_tracker_unit #(
  parameter int MAX_TRACKS = abmt_pkg::MaxTracksDefault
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         point_count,
  input  logic signed [15:0] first_x,
  input  logic signed [15:0] first_y,
  input  logic signed [15:0] second_x,
  input  logic signed [15:0] second_y,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               any_track,
  output logic [2:0]         slot,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [16:0] vel_x,
  output logic signed [16:0] vel_y,
  output logic [7:0]         misses,
  output logic               dropped_new,
  output logic               last
);
  import abmt_pkg::*;

  localparam int IW = $clog2(MAX_TRACKS);
  localparam int CW = $clog2(MAX_TRACKS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DSTART = 4'd1;
  localparam logic [3:0] S_DWAIT = 4'd2;
  localparam logic [3:0] S_DCMP  = 4'd3;
  localparam logic [3:0] S_DEC   = 4'd4;
  localparam logic [3:0] S_MISS  = 4'd5;
  localparam logic [3:0] S_UPD   = 4'd6;
  localparam logic [3:0] S_ADD   = 4'd7;
  localparam logic [3:0] S_COMP  = 4'd8;
  localparam logic [3:0] S_EMIT  = 4'd9;
  localparam logic [3:0] S_EMPTY = 4'd10;

  logic [3:0] state;
  track_t     tbl [MAX_TRACKS];
  logic [CW-1:0] total;
  logic [15:0] gate;
  logic [7:0]  limit;
  logic [1:0]  cnt;
  logic signed [15:0] ax, ay, bx, by;
  logic        pt;       // point under search
  logic [IW-1:0] idx;
  logic [CW-1:0] rd, wr;
  logic [33:0] best0, best1;
  logic [IW-1:0] near0, near1;
  logic        dropped;
  // update and add plan
  logic        upd0, upd1, add0, add1;
  logic        upd_ph, add_ph;
  logic [31:0] g2;
  logic        dstart, ddone;
  logic [33:0] dval;
  logic signed [15:0] qx, qy;
  track_t      ut, nt;
  logic signed [15:0] ux, uy;
  logic [IW-1:0] uidx;

  assign cfg_ready = 1'b1;
  assign in_ready = (state == S_IDLE);
  assign g2 = 32'(gate) * 32'(gate);

  assign qx = pt ? bx : ax;
  assign qy = pt ? by : ay;
  assign dstart = (state == S_DSTART);

  abmt_dist_unit u_dist (
    .clk(clk), .rst(rst), .start(dstart), .ax(qx), .ay(qy),
    .bx(tbl[idx].px), .by(tbl[idx].py), .done(ddone), .sum_sq(dval)
  );

  // gain-one-half update of the selected track
  assign uidx = upd_ph ? near1 : near0;
  assign ux = upd_ph ? bx : ax;
  assign uy = upd_ph ? by : ay;
  always_comb begin
    ut = tbl[uidx];
    nt.miss = 8'd0;
    nt.px = half_sat16(19'(ut.px) + 19'(ut.vx) + 19'(ux));
    nt.py = half_sat16(19'(ut.py) + 19'(ut.vy) + 19'(uy));
    nt.vx = half_sat17(19'(ut.vx) + 19'(ux) - 19'(ut.px));
    nt.vy = half_sat17(19'(ut.vy) + 19'(uy) - 19'(ut.py));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gate  <= GateReset;
      limit <= MissLimitReset;
    end else if (cfg_valid) begin
      if (cfg_index == CfgGate) gate <= cfg_data;
      else limit <= cfg_data[7:0];
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cnt <= point_count;
            ax <= first_x; ay <= first_y; bx <= second_x; by <= second_y;
            dropped <= 1'b0;
            pt <= 1'b0; idx <= '0;
            upd0 <= 1'b0; upd1 <= 1'b0;
            // an empty table takes the points as new tracks
            add0 <= (total == '0) && ((point_count == 2'd1) || (point_count == 2'd2));
            add1 <= (total == '0) && (point_count == 2'd2);
            upd_ph <= 1'b0; add_ph <= 1'b0;
            if (total == '0) begin
              state <= S_ADD;
            end else if (point_count == 2'd0) begin
              state <= S_MISS;
            end else if (point_count == 2'd3) begin
              state <= S_COMP;
            end else begin
              state <= S_DSTART;
            end
            rd <= '0; wr <= '0;
          end
        end
        S_DSTART: state <= S_DWAIT;
        S_DWAIT: if (ddone) state <= S_DCMP;
        S_DCMP: begin
          // first smallest distance wins
          if (!pt) begin
            if (idx == '0 || dval < best0) begin best0 <= dval; near0 <= idx; end
          end else begin
            if (idx == '0 || dval < best1) begin best1 <= dval; near1 <= idx; end
          end
          if (CW'(idx) + 1'b1 < total) begin
            idx <= idx + 1'b1;
            state <= S_DSTART;
          end else if (!pt && cnt == 2'd2) begin
            pt <= 1'b1; idx <= '0;
            state <= S_DSTART;
          end else begin
            state <= S_DEC;
          end
        end
        S_DEC: begin
          if (cnt == 2'd1) begin
            upd0 <= best0 < 34'(g2);
            add0 <= !(best0 < 34'(g2));
          end else if (near0 != near1) begin
            upd0 <= best0 <= 34'(g2); add0 <= !(best0 <= 34'(g2));
            upd1 <= best1 <= 34'(g2); add1 <= !(best1 <= 34'(g2));
          end else if (best0 < best1) begin
            upd0 <= best0 <= 34'(g2);
            add1 <= (best0 <= 34'(g2)) && !(best1 <= 34'(g2));
          end else begin
            upd1 <= best1 <= 34'(g2);
            add0 <= (best1 <= 34'(g2)) && !(best0 <= 34'(g2));
          end
          idx <= '0;
          state <= S_MISS;
        end
        S_MISS: begin
          // count a miss on each track, one per cycle
          if (tbl[idx].miss != 8'hff) tbl[idx].miss <= tbl[idx].miss + 1'b1;
          if (CW'(idx) + 1'b1 < total) idx <= idx + 1'b1;
          else state <= (cnt == 2'd0) ? S_COMP : S_UPD;
        end
        S_UPD: begin
          if (!upd_ph) begin
            if (upd0) tbl[near0] <= nt;
            upd_ph <= 1'b1;
          end else begin
            if (upd1) tbl[near1] <= nt;
            state <= S_ADD;
          end
        end
        S_ADD: begin
          // append unmatched points, first before second
          if ((!add_ph && add0) || (add_ph && add1)) begin
            if (total == CW'(MAX_TRACKS)) begin
              dropped <= 1'b1;
            end else begin
              tbl[total[IW-1:0]].px <= add_ph ? bx : ax;
              tbl[total[IW-1:0]].py <= add_ph ? by : ay;
              tbl[total[IW-1:0]].vx <= '0;
              tbl[total[IW-1:0]].vy <= '0;
              tbl[total[IW-1:0]].miss <= '0;
              total <= total + 1'b1;
            end
          end
          if (add_ph) state <= S_COMP;
          add_ph <= 1'b1;
        end
        S_COMP: begin
          // drop stale tracks, keeping order
          if (rd < total) begin
            if (tbl[rd[IW-1:0]].miss <= limit) begin
              tbl[wr[IW-1:0]] <= tbl[rd[IW-1:0]];
              wr <= wr + 1'b1;
            end
            rd <= rd + 1'b1;
          end else begin
            total <= wr;
            rd <= '0;
            out_valid <= 1'b1;
            state <= (wr == '0) ? S_EMPTY : S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (rd + 1'b1 < total) begin
              rd <= rd + 1'b1;
            end else begin
              out_valid <= 1'b0;
              state <= S_IDLE;
            end
          end
        end
        S_EMPTY: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output word from the current read slot
  always_comb begin
    any_track = (state == S_EMIT);
    slot = any_track ? 3'(rd) : 3'd0;
    pos_x = any_track ? tbl[rd[IW-1:0]].px : '0;
    pos_y = any_track ? tbl[rd[IW-1:0]].py : '0;
    vel_x = any_track ? tbl[rd[IW-1:0]].vx : '0;
    vel_y = any_track ? tbl[rd[IW-1:0]].vy : '0;
    misses = any_track ? tbl[rd[IW-1:0]].miss : '0;
    dropped_new = dropped;
    last = (state == S_EMPTY) || (rd + 1'b1 == total);
  end

endmodule

[rtl/abmt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// abmt_checker
// Port-level checks on the tracker's channels.
// ----------------------------------------------------------------------------
module abmt_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       any_track,
  input logic       last,
  input logic [2:0] slot
);
  // no scan taken while a result word is pending
  a_busy: assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input ready during emit");
  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(slot) && $stable(last))
    else $error("output word changed under stall");
  // empty-table word is always final
  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !any_track |-> last && slot == 3'd0)
    else $error("empty word not last");
  // slots advance by one
  a_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last |=> out_valid && slot == $past(slot) + 3'd1)
    else $error("slot skipped");
endmodule

bind alpha_beta_multi_target_tracker_unit abmt_checker u_abmt_checker (
  .clk(clk), .rst(rst), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .any_track(any_track), .last(last), .slot(slot)
);

[tb/sv/alpha_beta_multi_target_tracker_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alpha_beta_multi_target_tracker_unit_tb
// Self-checking bench for the multi-target tracker. Drives scans through the
// valid/ready input and keeps a behavioral copy of the track table. For each
// accepted scan it computes the emitted table, and it checks every output word
// field by field in order. A directed table of scans comes first. Random
// scans follow over several gate and miss-limit settings. Both sides idle at
// random, and the receiver also holds off for a long stretch.
// ----------------------------------------------------------------------------
module alpha_beta_multi_target_tracker_unit_tb;
  import abmt_pkg::*;

  localparam int NumTracks = 8;

  typedef struct {
    logic [1:0]         cnt;
    logic signed [15:0] ax, ay, bx, by;
  } scan_t;

  typedef struct {
    logic               any;
    logic [2:0]         slot;
    logic signed [15:0] px, py;
    logic signed [16:0] vx, vy;
    logic [7:0]         miss;
    logic               drop;
    logic               lst;
  } report_t;

  // directed row: a scan plus an optional typed word that stands in for the computed output
  typedef struct {
    scan_t   s;
    bit      typed;
    report_t r;
  } row_t;

  logic clk, rst;
  logic in_valid, in_ready;
  logic [1:0] point_count;
  logic signed [15:0] first_x, first_y, second_x, second_y;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [15:0] cfg_data;
  logic out_valid, out_ready, any_track;
  logic [2:0] slot;
  logic signed [15:0] pos_x, pos_y;
  logic signed [16:0] vel_x, vel_y;
  logic [7:0] misses;
  logic dropped_new, last;

  alpha_beta_multi_target_tracker_unit dut (.*);

  // tracker copy
  longint tpx[NumTracks], tpy[NumTracks], tvx[NumTracks], tvy[NumTracks];
  int     tmiss[NumTracks];
  int     total;
  longint gate_mm;
  int     limit_cnt;

  report_t pending_reports[$];
  row_t    dir_rows[$];
  int      errors;
  bit      quiet;
  bit      hold_req;
  int      hold_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("alpha_beta_multi_target_tracker_unit_tb: done, errors");
    $finish;
  end

  // append an expected word at the tail
  function automatic void queue_report(report_t r);
    pending_reports = {pending_reports, r};
  endfunction

  // append a directed row
  function automatic void add_row(scan_t s, bit typed, report_t r);
    row_t rw;
    rw.s = s;
    rw.typed = typed;
    rw.r = r;
    dir_rows = {dir_rows, rw};
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint dist_sq(int i, longint x, longint y);
    longint dx, dy;
    dx = x - tpx[i];
    dy = y - tpy[i];
    return dx * dx + dy * dy;
  endfunction

  function automatic int nearest_track(longint x, longint y, output longint d);
    int best;
    longint c;
    best = 0;
    d = dist_sq(0, x, y);
    for (int i = 1; i < total; i++) begin
      c = dist_sq(i, x, y);
      if (c < d) begin
        d = c;
        best = i;
      end
    end
    return best;
  endfunction

  function automatic void miss_all();
    for (int i = 0; i < total; i++)
      if (tmiss[i] < 255) tmiss[i]++;
  endfunction

  function automatic void add_track(longint x, longint y, ref bit drop);
    if (total >= NumTracks) begin
      drop = 1'b1;
      return;
    end
    tpx[total] = x; tpy[total] = y;
    tvx[total] = 0; tvy[total] = 0;
    tmiss[total] = 0;
    total++;
  endfunction

  function automatic void update_track(int i, longint x, longint y);
    longint ox, oy;
    ox = tpx[i];
    oy = tpy[i];
    tmiss[i] = 0;
    tpx[i] = clamp((ox + tvx[i] + x) >>> 1, -32768, 32767);
    tpy[i] = clamp((oy + tvy[i] + y) >>> 1, -32768, 32767);
    tvx[i] = clamp((tvx[i] + x - ox) >>> 1, -65536, 65535);
    tvy[i] = clamp((tvy[i] + y - oy) >>> 1, -65536, 65535);
  endfunction

  // advance the track table by one scan and queue the words it emits
  function automatic void track_scan(scan_t s, bit typed, report_t typed_r);
    longint ax, ay, bx, by, d0, d1, g2;
    int i0, i1, w;
    bit in0, in1, drop;
    report_t r;
    ax = s.ax; ay = s.ay; bx = s.bx; by = s.by;
    g2 = gate_mm * gate_mm;
    drop = 1'b0;
    if (total == 0) begin
      if (s.cnt == 2'd1 || s.cnt == 2'd2) add_track(ax, ay, drop);
      if (s.cnt == 2'd2) add_track(bx, by, drop);
    end else if (s.cnt == 2'd0) begin
      miss_all();
    end else if (s.cnt == 2'd1) begin
      i0 = nearest_track(ax, ay, d0);
      miss_all();
      if (d0 < g2) update_track(i0, ax, ay);
      else add_track(ax, ay, drop);
    end else if (s.cnt == 2'd2) begin
      i0 = nearest_track(ax, ay, d0);
      i1 = nearest_track(bx, by, d1);
      in0 = d0 <= g2;
      in1 = d1 <= g2;
      miss_all();
      if (i0 != i1) begin
        if (in0) update_track(i0, ax, ay);
        if (in1) update_track(i1, bx, by);
        if (!in0) add_track(ax, ay, drop);
        if (!in1) add_track(bx, by, drop);
      end else if (d0 < d1) begin
        if (in0) begin
          update_track(i0, ax, ay);
          if (!in1) add_track(bx, by, drop);
        end
      end else if (in1) begin
        update_track(i1, bx, by);
        if (!in0) add_track(ax, ay, drop);
      end
    end
    // drop expired tracks, keep order
    w = 0;
    for (int k = 0; k < total; k++) begin
      if (tmiss[k] > limit_cnt) continue;
      tpx[w] = tpx[k]; tpy[w] = tpy[k];
      tvx[w] = tvx[k]; tvy[w] = tvy[k];
      tmiss[w] = tmiss[k];
      w++;
    end
    total = w;
    if (typed) begin
      queue_report(typed_r);
      return;
    end
    if (total == 0) begin
      r = '{default: '0};
      r.drop = drop;
      r.lst = 1'b1;
      queue_report(r);
      return;
    end
    for (int k = 0; k < total; k++) begin
      r.any = 1'b1;
      r.slot = k[2:0];
      r.px = tpx[k][15:0];
      r.py = tpy[k][15:0];
      r.vx = tvx[k][16:0];
      r.vy = tvy[k][16:0];
      r.miss = tmiss[k][7:0];
      r.drop = drop;
      r.lst = (k == total - 1);
      queue_report(r);
    end
  endfunction

  // random scan: mostly points that follow live tracks, some noise
  function automatic scan_t make_scan();
    scan_t s;
    int pick, sel;
    longint x, y;
    s.ax = 16'($urandom); s.ay = 16'($urandom);
    s.bx = 16'($urandom); s.by = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 8) s.cnt = 2'd0;
    else if (pick < 12) s.cnt = 2'd3;
    else s.cnt = 2'($urandom_range(1, 2));
    if (total > 0 && $urandom_range(99) < 75) begin
      for (int p = 0; p < 2; p++) begin
        sel = $urandom_range(total - 1);
        x = clamp(tpx[sel] + tvx[sel] + $urandom_range(800) - 400, -32768, 32767);
        y = clamp(tpy[sel] + tvy[sel] + $urandom_range(800) - 400, -32768, 32767);
        if (p == 0) begin
          s.ax = 16'(x); s.ay = 16'(y);
        end else if ($urandom_range(3) != 0) begin
          s.bx = 16'(x); s.by = 16'(y);
        end
      end
    end
    return s;
  endfunction

  task automatic send_scan(scan_t s, bit typed, report_t r);
    in_valid <= 1'b1;
    point_count <= s.cnt;
    first_x <= s.ax; first_y <= s.ay;
    second_x <= s.bx; second_y <= s.by;
    do @(posedge clk); while (!in_ready);
    track_scan(s, typed, r);
    // idle between scans at random
    if (!quiet && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CfgGate) gate_mm = 64'(data);
    else limit_cnt = int'(data[7:0]);
    @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_cnt = 400;
      hold_req = 1'b0;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 25);
    end
  end

  // check each output word against the oldest pending one
  always @(posedge clk) begin
    report_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("unexpected output word");
        errors++;
      end else begin
        e = pending_reports[0];
        pending_reports.delete(0);
        if (any_track !== e.any) begin
          $error("any_track exp %0d got %0d", e.any, any_track); errors++;
        end
        if (slot !== e.slot) begin
          $error("slot exp %0d got %0d", e.slot, slot); errors++;
        end
        if (pos_x !== e.px) begin
          $error("pos_x exp %0d got %0d", e.px, pos_x); errors++;
        end
        if (pos_y !== e.py) begin
          $error("pos_y exp %0d got %0d", e.py, pos_y); errors++;
        end
        if (vel_x !== e.vx) begin
          $error("vel_x exp %0d got %0d", e.vx, vel_x); errors++;
        end
        if (vel_y !== e.vy) begin
          $error("vel_y exp %0d got %0d", e.vy, vel_y); errors++;
        end
        if (misses !== e.miss) begin
          $error("misses exp %0d got %0d", e.miss, misses); errors++;
        end
        if (dropped_new !== e.drop) begin
          $error("dropped_new exp %0d got %0d", e.drop, dropped_new); errors++;
        end
        if (last !== e.lst) begin
          $error("last exp %0d got %0d", e.lst, last); errors++;
        end
      end
    end
  end

  initial begin
    report_t none;
    report_t empty_r;
    report_t corner_r;
    scan_t s;
    int n;
    longint gates[6];
    int limits[6];

    errors = 0; quiet = 1'b0; hold_req = 1'b0; hold_cnt = 0;
    total = 0; gate_mm = 64'(GateReset); limit_cnt = int'(MissLimitReset);
    rst = 1'b1; in_valid = 1'b0; point_count = '0;
    first_x = '0; first_y = '0; second_x = '0; second_y = '0;
    cfg_valid = 1'b0; cfg_index = CfgGate; cfg_data = '0;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    none = '{default: '0};
    empty_r = '{default: '0};
    empty_r.lst = 1'b1;
    corner_r = '{any: 1'b1, slot: 3'd0, px: 16'sh7fff, py: 16'sh8000,
                 vx: '0, vy: '0, miss: '0, drop: 1'b0, lst: 1'b1};

    // directed scans under the reset settings
    add_row('{2'd0, 0, 0, 0, 0}, 1, empty_r);            // empty, no points
    add_row('{2'd3, 1, 2, 3, 4}, 1, empty_r);            // count three ignored
    add_row('{2'd1, 32767, -32768, 0, 0}, 1, corner_r);  // first track
    add_row('{2'd1, 32767, -32768, 0, 0}, 0, none);      // exact hit
    add_row('{2'd1, 32267, -32768, 0, 0}, 0, none);      // on gate: new track
    add_row('{2'd2, -32768, 32767, -32000, 32000}, 0, none); // same nearest
    add_row('{2'd2, 32767, -32768, 0, 0}, 0, none);      // closer in, other added
    add_row('{2'd2, 100, 0, -100, 0}, 0, none);          // tie, second wins
    add_row('{2'd2, 32767, -32268, 500, 0}, 0, none);    // different nearest, on gate
    add_row('{2'd3, 0, 0, 0, 0}, 0, none);
    add_row('{2'd2, -32768, -32768, 32767, 32767}, 0, none);
    add_row('{2'd2, -20000, 20000, 20000, -20000}, 0, none);
    add_row('{2'd2, -10000, 10000, 10000, -10000}, 0, none);
    add_row('{2'd2, 5000, 5000, -5000, -5000}, 0, none); // table fills, drops
    add_row('{2'd1, -1, -1, 0, 0}, 0, none);
    add_row('{2'd0, 0, 0, 0, 0}, 0, none);
    add_row('{2'd1, -32768, -32768, 0, 0}, 0, none);
    add_row('{2'd1, -32768, -32768, 0, 0}, 0, none);
    foreach (dir_rows[i]) send_scan(dir_rows[i].s, dir_rows[i].typed, dir_rows[i].r);
    drain();

    // random phases over register settings, extremes among them
    gates = '{0, 65535, 300, 500, 2000, 0};
    limits = '{0, 254, 255, 3, 10, 0};
    gates[5] = $urandom_range(65535);
    limits[5] = $urandom_range(255);
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CfgGate, gates[ph][15:0]);
      write_reg(CfgLimit, limits[ph][15:0]);
      quiet = (ph == 2);
      if (ph == 3) hold_req = 1'b1;
      n = (ph == 1) ? 4 : 25;
      for (int k = 0; k < n; k++) begin
        s = make_scan();
        send_scan(s, 0, none);
      end
      // sender pauses until everything is out
      drain();
    end
    quiet = 1'b0;
    write_reg(CfgLimit, 16'hff00);
    for (int k = 0; k < 5; k++) begin
      s = make_scan();
      send_scan(s, 0, none);
    end
    drain();
    repeat (100) @(posedge clk);

    if (errors == 0 && pending_reports.size() == 0)
      $display("alpha_beta_multi_target_tracker_unit_tb: done, clean");
    else
      $display("alpha_beta_multi_target_tracker_unit_tb: done, errors");
    $finish;
  end

endmodule
